// ===== sv/assert_macros.svh =====
// Assertion helper macros for the semaphore block.
// Included by RTL files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define CSF_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check, active in reset too.
`define CSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/csf_pkg.sv =====
// Shared types and constants for the counting semaphore with FIFO waiters.
// No dependencies; used by csf_queue and the core top level.
`default_nettype none

package csf_pkg;

    localparam int CSF_WAITERS    = 16;
    localparam int CSF_COUNT_BITS = 16;
    localparam int ID_W           = 4;
    localparam int KIND_W         = 3;
    localparam int INIT_W         = 16;
    localparam int OUT_DATA_W     = 32;
    localparam int IN_DATA_W      = 8;

    typedef enum logic [KIND_W-1:0] {
        K_TRY     = 3'd0,
        K_ACQ     = 3'd1,
        K_CANCEL  = 3'd2,
        K_RELEASE = 3'd3,
        K_POLL    = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        E_OK     = 2'd0,
        E_FULL   = 2'd1,
        E_QUEUED = 2'd2,
        E_SAT    = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        Q_NONE,
        Q_APPEND,
        Q_CANCEL,
        Q_RELEASE,
        Q_GRANT
    } qop_t;

    typedef struct packed {
        logic clear;
        qop_t op;
    } q_cmd_t;

    typedef struct packed {
        logic nonempty;
        logic waiting;
        logic cancellable;
    } q_status_t;

endpackage

`default_nettype wire

// ===== sv/csf_queue.sv =====
// Waiter queue: circular doubly linked list in flops plus per-waiter flags.
// Depends on csf_pkg for command and status types.
`default_nettype none

module csf_queue import csf_pkg::*; #(
    parameter  int WAITERS = CSF_WAITERS,
    localparam int IDX_W   = $clog2(WAITERS)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire q_cmd_t           cmd,
    input  wire logic [IDX_W-1:0] idx,
    output q_status_t             status,
    output logic      [IDX_W-1:0] head
);

    logic               nonempty_reg, nonempty_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [WAITERS-1:0] wait_reg, wait_next;
    logic [WAITERS-1:0] canc_reg, canc_next;
    logic [IDX_W-1:0]   next_reg [WAITERS];
    logic [IDX_W-1:0]   next_next [WAITERS];
    logic [IDX_W-1:0]   prev_reg [WAITERS];
    logic [IDX_W-1:0]   prev_next [WAITERS];

    logic [IDX_W-1:0] n, p, q, t;
    logic             do_unlink;

    assign n = (cmd.op == Q_RELEASE) ? head_reg : idx;
    assign p = prev_reg[n];
    assign q = next_reg[n];
    assign t = prev_reg[head_reg];

    assign do_unlink = nonempty_reg &&
                       ((cmd.op == Q_RELEASE) ||
                        ((cmd.op == Q_CANCEL) && wait_reg[idx] && canc_reg[idx]));

    always_comb
    begin
        nonempty_next = nonempty_reg;
        head_next     = head_reg;
        wait_next     = wait_reg;
        canc_next     = canc_reg;
        next_next     = next_reg;
        prev_next     = prev_reg;

        case (cmd.op)
            Q_APPEND:
            begin
                wait_next[idx] = 1'b1;
                canc_next[idx] = 1'b1;
                if (nonempty_reg)
                begin
                    next_next[idx]      = head_reg;
                    prev_next[idx]      = t;
                    next_next[t]        = idx;
                    prev_next[head_reg] = idx;
                end
                else
                begin
                    next_next[idx] = idx;
                    prev_next[idx] = idx;
                    head_next      = idx;
                    nonempty_next  = 1'b1;
                end
            end
            Q_CANCEL:  canc_next[idx] = 1'b0;
            Q_RELEASE: wait_next[head_reg] = 1'b0;
            Q_GRANT:   wait_next[idx] = 1'b0;
            default:   ;
        endcase

        if (do_unlink)
        begin
            next_next[p] = q;
            prev_next[q] = p;
            if (head_reg == n)
            begin
                if (q == n)
                    nonempty_next = 1'b0;
                else
                    head_next = q;
            end
        end

        if (cmd.clear)
        begin
            nonempty_next = 1'b0;
            head_next     = '0;
            wait_next     = '0;
            canc_next     = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nonempty_reg <= 1'b0;
            head_reg     <= '0;
            wait_reg     <= '0;
            canc_reg     <= '0;
        end
        else
        begin
            nonempty_reg <= nonempty_next;
            head_reg     <= head_next;
            wait_reg     <= wait_next;
            canc_reg     <= canc_next;
        end
    end

    // links are only read for entries in the queue, so no reset
    always_ff @(posedge clk)
    begin
        next_reg <= next_next;
        prev_reg <= prev_next;
    end

    assign status.nonempty    = nonempty_reg;
    assign status.waiting     = wait_reg[idx];
    assign status.cancellable = canc_reg[idx];
    assign head               = head_reg;

endmodule

`default_nettype wire

// ===== sv/counting_semaphore_fifo_waiters_core.sv =====
// Stages: input register, then result register; a stalled result holds the input.
// Throughput: one request per cycle unless results stall; queue updates with count.
// Reset: rst_n async low clears count, initial_count, queue and flags.
// A write of initial_count reloads the count and empties the queue.
// Depends on csf_pkg, csf_queue and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module counting_semaphore_fifo_waiters_core import csf_pkg::*; #(
    parameter int WAITERS    = CSF_WAITERS,
    parameter int COUNT_BITS = CSF_COUNT_BITS
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // [3:0] waiter_id
    input  wire logic [KIND_W-1:0]     s_axis_tuser,  // [2:0] kind
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [15:0] old_count, [16] granted, [17] queued, [18] woken_valid,
    // [22:19] woken_id, [23] waiter_done, [24] waiter_finished, [26:25] error
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [2:0]            paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int IDX_W = $clog2(WAITERS);
    localparam int IDW   = IDX_W + ID_W;
    localparam logic [COUNT_BITS-1:0] CNT_ONE = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    // config port
    logic              cfg_wr;
    logic [INIT_W-1:0] init_reg;
    logic [31:0]       init_ext;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign init_ext = {16'b0, pwdata[INIT_W-1:0]};
    assign prdata   = (paddr[2] == 1'b0) ? {16'b0, init_reg} : 32'b0;

    // input register
    logic            in_valid_reg;
    kind_t           kind_reg;
    logic [ID_W-1:0] id_reg;
    logic            advance;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // queue
    q_cmd_t           q_cmd;
    q_status_t        q_st;
    logic [IDX_W-1:0] q_head;
    logic [IDX_W-1:0] idx;
    logic [IDW-1:0]   id_wide;
    logic [IDW-1:0]   head_wide;
    logic             in_range;
    qop_t             op;

    assign id_wide   = IDW'(id_reg);
    assign idx       = id_wide[IDX_W-1:0];
    assign head_wide = IDW'(q_head);
    assign in_range  = (32'(id_reg) < WAITERS);
    assign q_cmd.clear = cfg_wr;
    assign q_cmd.op    = advance ? op : Q_NONE;

    csf_queue #(
        .WAITERS (WAITERS)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (q_cmd),
        .idx    (idx),
        .status (q_st),
        .head   (q_head)
    );

    // operation logic
    logic [COUNT_BITS-1:0] unit_count_reg, unit_count_next;
    logic [31:0]           unit_ext;
    logic [15:0]           old_count;
    logic                  granted, queued, woken_valid, waiter_done, waiter_finished;
    logic [ID_W-1:0]       woken_id;
    err_t                  error;
    logic                  cnt_nz;

    assign unit_ext = 32'(unit_count_reg);
    assign cnt_nz   = (unit_count_reg != '0);

    always_comb
    begin
        op              = Q_NONE;
        unit_count_next = unit_count_reg;
        old_count       = '0;
        granted         = 1'b0;
        queued          = 1'b0;
        woken_valid     = 1'b0;
        woken_id        = '0;
        waiter_done     = 1'b0;
        waiter_finished = 1'b0;
        error           = E_OK;

        case (kind_reg)
            K_TRY:
            begin
                old_count = unit_ext[15:0];
                if (cnt_nz)
                begin
                    unit_count_next = unit_count_reg - CNT_ONE;
                    granted         = 1'b1;
                end
            end
            K_ACQ:
            begin
                if (in_range && q_st.waiting && q_st.cancellable)
                begin
                    old_count = unit_ext[15:0];
                    error     = E_QUEUED;
                end
                else if (cnt_nz)
                begin
                    old_count       = unit_ext[15:0];
                    unit_count_next = unit_count_reg - CNT_ONE;
                    granted         = 1'b1;
                    if (in_range)
                        op = Q_GRANT;
                end
                else if (!in_range)
                    error = E_FULL;
                else
                begin
                    op     = Q_APPEND;
                    queued = 1'b1;
                end
            end
            K_CANCEL:
            begin
                if (in_range)
                    op = Q_CANCEL;
            end
            K_RELEASE:
            begin
                old_count = unit_ext[15:0];
                if (q_st.nonempty)
                begin
                    op          = Q_RELEASE;
                    woken_valid = 1'b1;
                    woken_id    = head_wide[ID_W-1:0];
                end
                else if (unit_count_reg == CNT_MAX)
                    error = E_SAT;
                else
                    unit_count_next = unit_count_reg + CNT_ONE;
            end
            K_POLL:
            begin
                if (in_range)
                begin
                    waiter_finished = !q_st.waiting;
                    waiter_done     = !q_st.waiting || !q_st.cancellable;
                end
                else
                begin
                    waiter_finished = 1'b1;
                    waiter_done     = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg       <= '0;
            unit_count_reg <= '0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                init_reg       <= pwdata[INIT_W-1:0];
                unit_count_reg <= init_ext[COUNT_BITS-1:0];
            end
            else if (advance)
                unit_count_reg <= unit_count_next;

            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            kind_reg <= kind_t'(s_axis_tuser);
            id_reg   <= s_axis_tdata[ID_W-1:0];
        end
        if (advance)
            out_data_reg <= {5'b0, error, waiter_finished, waiter_done, woken_id,
                             woken_valid, queued, granted, old_count};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    `CSF_ASSERT_RST(a_append_fills, clk, rst_n,
        (advance && (op == Q_APPEND) && !cfg_wr) |=> q_st.nonempty,
        "queue empty after append")
    `CSF_ASSERT_RST(a_wake_keeps_count, clk, rst_n,
        (advance && (op == Q_RELEASE) && !cfg_wr) |=> $stable(unit_count_reg),
        "count changed on hand-off to waiter")
    `CSF_ASSERT_RST(a_grant_xor_queue, clk, rst_n,
        !(out_valid_reg && out_data_reg[16] && out_data_reg[17]),
        "result both granted and queued")

endmodule

`default_nettype wire

// ===== test/csf_checker.sv =====
// Checker for the counting semaphore: watches request, result and register ports,
// predicts each result and compares it. Depends on csf_pkg.
`timescale 1ns / 1ps

module csf_checker import csf_pkg::*; #(
    parameter logic [2:0] INIT_ADDR = 3'd0
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    input  wire logic                   s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]   s_axis_tdata,
    input  wire logic [KIND_W-1:0]      s_axis_tuser,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [2:0]             paddr,
    input  wire logic [31:0]            pwdata,
    input  wire logic [31:0]            prdata,
    input  wire logic                   pready,
    output int                          failures,
    output int                          outstanding
);

    // result word, highest bits first
    typedef struct packed {
        logic [4:0]                pad;
        err_t                      err;
        logic                      finished;
        logic                      done;
        logic [ID_W-1:0]           woken_id;
        logic                      woken_valid;
        logic                      queued;
        logic                      granted;
        logic [CSF_COUNT_BITS-1:0] old_count;
    } sem_result_t;

    logic [CSF_COUNT_BITS-1:0] init_value;
    logic [CSF_COUNT_BITS-1:0] units;
    logic                      q_busy;
    logic [ID_W-1:0]           q_head;
    logic [ID_W-1:0]           nxt [CSF_WAITERS];
    logic [ID_W-1:0]           prv [CSF_WAITERS];
    logic                      waiting [CSF_WAITERS];
    logic                      cancellable [CSF_WAITERS];
    sem_result_t               results_due [$];
    int                        mismatches = 0;

    function automatic void clear_waiters();
        q_busy = 1'b0;
        q_head = '0;
        for (int i = 0; i < CSF_WAITERS; i++)
        begin
            nxt[i]         = '0;
            prv[i]         = '0;
            waiting[i]     = 1'b0;
            cancellable[i] = 1'b0;
        end
    endfunction

    function automatic void unlink_waiter(input logic [ID_W-1:0] n);
        logic [ID_W-1:0] p;
        logic [ID_W-1:0] q;
        p      = prv[n];
        q      = nxt[n];
        nxt[p] = q;
        prv[q] = p;
        if (q_head == n)
        begin
            if (q == n)
                q_busy = 1'b0;
            else
                q_head = q;
        end
    endfunction

    function automatic void append_waiter(input logic [ID_W-1:0] n);
        logic [ID_W-1:0] t;
        if (q_busy)
        begin
            t           = prv[q_head];
            nxt[n]      = q_head;
            prv[n]      = t;
            nxt[t]      = n;
            prv[q_head] = n;
        end
        else
        begin
            nxt[n] = n;
            prv[n] = n;
            q_head = n;
            q_busy = 1'b1;
        end
    endfunction

    // ids are 4 bits and there are 16 waiters, so every id is in range
    function automatic sem_result_t serve_request(input logic [KIND_W-1:0] kind,
                                                  input logic [ID_W-1:0] id);
        sem_result_t r;
        logic [ID_W-1:0] n;
        r = '0;
        case (kind)
            K_TRY:
            begin
                r.old_count = units;
                if (units != 0)
                begin
                    units     = units - 1'b1;
                    r.granted = 1'b1;
                end
            end
            K_ACQ:
            begin
                if (waiting[id] && cancellable[id])
                begin
                    r.old_count = units;
                    r.err       = E_QUEUED;
                end
                else if (units != 0)
                begin
                    r.old_count = units;
                    units       = units - 1'b1;
                    r.granted   = 1'b1;
                    waiting[id] = 1'b0;
                end
                else
                begin
                    waiting[id]     = 1'b1;
                    cancellable[id] = 1'b1;
                    append_waiter(id);
                    r.queued = 1'b1;
                end
            end
            K_CANCEL:
            begin
                if (waiting[id] && cancellable[id] && q_busy)
                    unlink_waiter(id);
                cancellable[id] = 1'b0;
            end
            K_RELEASE:
            begin
                r.old_count = units;
                if (q_busy)
                begin
                    n          = q_head;
                    waiting[n] = 1'b0;
                    unlink_waiter(n);
                    r.woken_valid = 1'b1;
                    r.woken_id    = n;
                end
                else if (&units)
                    r.err = E_SAT;
                else
                    units = units + 1'b1;
            end
            K_POLL:
            begin
                r.finished = !waiting[id];
                r.done     = !waiting[id] || !cancellable[id];
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic void report_result(input string what, input sem_result_t want,
                                          input sem_result_t got);
        if (mismatches < 10)
        begin
            $display("%0t: %s", $time, what);
            $display("  expected old=%0d g=%0b q=%0b wv=%0b wid=%0d dn=%0b fn=%0b e=%0d p=%h",
                     want.old_count, want.granted, want.queued, want.woken_valid,
                     want.woken_id, want.done, want.finished, want.err, want.pad);
            $display("  got      old=%0d g=%0b q=%0b wv=%0b wid=%0d dn=%0b fn=%0b e=%0d p=%h",
                     got.old_count, got.granted, got.queued, got.woken_valid,
                     got.woken_id, got.done, got.finished, got.err, got.pad);
        end
        mismatches++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        sem_result_t seen;
        if (!rst_n)
        begin
            init_value = '0;
            units      = '0;
            clear_waiters();
            results_due.delete();
            outstanding <= 0;
            failures    <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = sem_result_t'(m_axis_tdata);
                if (results_due.size() == 0)
                    report_result("result with no request pending", '0, seen);
                else if (seen !== results_due[0])
                    report_result("result mismatch", results_due[0], seen);
                if (results_due.size() != 0)
                    void'(results_due.pop_front());
            end
            if (s_axis_tvalid && s_axis_tready)
                results_due.push_back(serve_request(s_axis_tuser, s_axis_tdata[ID_W-1:0]));
            if (psel && penable && pready && paddr == INIT_ADDR)
            begin
                if (pwrite)
                begin
                    init_value = pwdata[CSF_COUNT_BITS-1:0];
                    units      = init_value;
                    clear_waiters();
                end
                else if (prdata !== 32'(init_value))
                begin
                    if (mismatches < 10)
                        $display("%0t: initial_count readback expected %h got %h",
                                 $time, 32'(init_value), prdata);
                    mismatches++;
                end
            end
            outstanding <= results_due.size();
            failures    <= mismatches;
        end
    end

endmodule

// ===== test/tb_counting_semaphore_fifo_waiters_core.sv =====
// Top of the semaphore testbench: clock, reset, request and register stimulus,
// result back-pressure and verdict. Depends on csf_pkg, csf_checker and the core.
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_waiters_core;
    import csf_pkg::*;

    localparam logic [2:0]        ADDR_INITIAL_COUNT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SPARE_LO      = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_MID     = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI      = 3'd7;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASES         = 8;
    localparam int REQS_PER_PHASE = 90;
    localparam int DIRECTED_REQS  = 23;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;  // [3:0] waiter_id
    logic [KIND_W-1:0]     s_axis_tuser = '0;  // [2:0] kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [15:0] old_count, [16] granted, [17] queued, [18] woken_valid,
    // [22:19] woken_id, [23] waiter_done, [24] waiter_finished, [26:25] error
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [2:0]            paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int failures;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;
    int hold_reqs = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    counting_semaphore_fifo_waiters_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    csf_checker #(.INIT_ADDR(ADDR_INITIAL_COUNT)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .failures      (failures),
        .outstanding   (outstanding)
    );

    // result side: random stalls, plus a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_reqs != hold_served)
        begin
            hold_served = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= IN_DATA_W'(id);
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic random_request();
        int pick;
        logic [KIND_W-1:0] kind;
        pick = $urandom_range(0, 99);
        if (pick < 36)
            kind = K_ACQ;
        else if (pick < 62)
            kind = K_RELEASE;
        else if (pick < 74)
            kind = K_CANCEL;
        else if (pick < 86)
            kind = K_POLL;
        else if (pick < 95)
            kind = K_TRY;
        else
            kind = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
        send_request(kind, ID_W'($urandom_range(0, CSF_WAITERS - 1)));
    endtask

    // stop sending and wait for every result
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic reg_access(input logic wr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_INITIAL_COUNT;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_count(input logic [CSF_COUNT_BITS-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        reg_access(1'b1, 32'(value));
        reg_access(1'b0, '0);
    endtask

    logic [KIND_W-1:0] dir_kind [DIRECTED_REQS] = '{
        K_TRY, K_ACQ, K_ACQ, K_ACQ, K_ACQ, K_POLL, K_CANCEL, K_POLL,
        K_CANCEL, K_ACQ, K_RELEASE, K_POLL, K_CANCEL, K_RELEASE, K_ACQ, K_CANCEL,
        K_RELEASE, K_ACQ, KIND_SPARE_LO, KIND_SPARE_MID, KIND_SPARE_HI, K_RELEASE, K_TRY
    };
    logic [ID_W-1:0] dir_id [DIRECTED_REQS] = '{
        0, 0, 15, 7, 15, 15, 15, 15,
        15, 15, 0, 0, 7, 0, 4, 4,
        0, 9, 15, 15, 15, 0, 0
    };
    int phase_count [PHASES] = '{0, 1, 3, 65535, 2, 0, 65534, 1};
    int phase_idle  [4] = '{0, 48, 0, 11};
    int phase_stall [4] = '{0, 0, 48, 11};

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // count 0: queue build-up, duplicate acquire, cancels in middle, head and sole entry
        for (int i = 0; i < DIRECTED_REQS; i++)
            send_request(dir_kind[i], dir_id[i]);

        // full count: saturating release
        load_count('1);
        send_request(K_RELEASE, 0);
        send_request(K_TRY, 0);
        send_request(K_RELEASE, 0);
        send_request(K_RELEASE, 15);
        send_request(K_ACQ, 15);

        for (int p = 0; p < PHASES; p++)
        begin
            load_count(p == 5 ? CSF_COUNT_BITS'($urandom_range(0, 8)) :
                                CSF_COUNT_BITS'(phase_count[p]));
            idle_pct  = phase_idle[p % 4];
            stall_pct = phase_stall[p % 4];
            if (p == 4)
                hold_reqs++;
            repeat (REQS_PER_PHASE) random_request();
        end

        drain();
        repeat (10) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
